### design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants for bounded_subset_sum_reach
// Action codes, field widths and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

    localparam int FIELD_W = 12;   // weight, multiplicity, query_sum
    localparam int ACT_W   = 2;
    localparam int CNT_W   = 13;   // window count

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item fields
        logic add_start;  // reset walk pointers
        logic walk;       // issue one bitmap position
        logic flip;       // swap live and shadow banks
        logic clr_start;  // restart clear sweep
        logic clr_wr;     // write one clear entry
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;  // last position of the add walk issued now
        logic clr_last;   // last clear entry written now
        logic q_bit;      // queried bit (0 when out of range)
    } t_dp_sts;

endpackage

`default_nettype wire

### design/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram: generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/bsr_dp.sv
// ----------------------------------------------------------------------------
// bsr_dp: datapath
// Two bitmap banks (live / shadow), residue-class walk pointers, the
// sliding window count and the clear sweep counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_dp #(
    parameter int MAX_SUM = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bsr_pkg::FIELD_W-1:0]   i_weight,
    input  wire logic [bsr_pkg::FIELD_W-1:0]   i_mult,
    input  wire logic [bsr_pkg::FIELD_W-1:0]   i_query_sum,
    input  wire bsr_pkg::t_dp_cmd              i_cmd,
    output bsr_pkg::t_dp_sts                   o_sts
);

    localparam int AW = $clog2(MAX_SUM);
    localparam int SW = ((AW > bsr_pkg::FIELD_W) ? AW : bsr_pkg::FIELD_W) + 1;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_SUM);
    localparam int CW = bsr_pkg::CNT_W;

    // item fields
    logic [bsr_pkg::FIELD_W-1:0] r_w;
    logic [bsr_pkg::FIELD_W-1:0] r_c;
    logic [SW-1:0]               r_q;
    logic                        r_q_ok;

    // walk pointers
    logic [SW-1:0] r_r, r_j, r_tail, r_k;
    logic [SW-1:0] n_j_step, n_r_step, w_ext, c_ext;
    logic          class_end, res_last, drop, first;

    // read-data stage
    logic          r_p_valid, r_p_first, r_p_drop;
    logic [AW-1:0] r_p_addr;
    logic [CW-1:0] r_count, n_count, count_eff;
    logic          n_bit;

    // banks
    logic          r_sel;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] rd_addr_a, wr_addr;
    logic          wr_data, we0, we1;
    logic          b0_a, b0_b, b1_a, b1_b, rd_a, rd_b;

    assign w_ext     = SW'(r_w);
    assign c_ext     = SW'(r_c);
    assign n_j_step  = r_j + w_ext;
    assign n_r_step  = r_r + SW'(1);
    assign class_end = (n_j_step >= MAX_S);
    assign res_last  = (n_r_step >= w_ext) || (n_r_step >= MAX_S);
    assign drop      = (r_k > c_ext);
    assign first     = (r_k == '0);

    // window step: drop oldest, test, then add current position
    assign rd_a      = r_sel ? b1_a : b0_a;
    assign rd_b      = r_sel ? b1_b : b0_b;
    assign count_eff = (r_p_first ? CW'(0) : r_count) - ((r_p_drop && rd_b) ? CW'(1) : CW'(0));
    assign n_bit     = rd_a | (count_eff != '0);
    assign n_count   = count_eff + CW'(rd_a);

    // port a: walk head or query address; port b: window tail
    assign rd_addr_a = i_cmd.walk ? r_j[AW-1:0] : r_q[AW-1:0];

    // clear writes the live bank, the walk writes the shadow bank
    assign wr_addr = i_cmd.clr_wr ? r_clr : r_p_addr;
    assign wr_data = i_cmd.clr_wr ? (r_clr == '0) : n_bit;
    assign we0     = (i_cmd.clr_wr && !r_sel) || (r_p_valid && r_sel);
    assign we1     = (i_cmd.clr_wr &&  r_sel) || (r_p_valid && !r_sel);

    assign o_sts.walk_last = class_end && res_last;
    assign o_sts.clr_last  = (r_clr == AW'(MAX_SUM - 1));
    assign o_sts.q_bit     = r_q_ok & rd_a;

    bsr_ram #(.WIDTH(1), .DEPTH(MAX_SUM)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (b0_a),
        .i_raddr_b (r_tail[AW-1:0]),
        .o_rdata_b (b0_b)
    );

    bsr_ram #(.WIDTH(1), .DEPTH(MAX_SUM)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (b1_a),
        .i_raddr_b (r_tail[AW-1:0]),
        .o_rdata_b (b1_b)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_p_valid <= 1'b0;
            r_clr     <= '0;
            r_count   <= '0;
        end else begin
            r_p_valid <= i_cmd.walk;
            if (i_cmd.flip) begin
                r_sel <= ~r_sel;
            end
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_p_valid) begin
                r_count <= n_count;
            end
        end
    end

    // payload and walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w    <= i_weight;
            r_c    <= i_mult;
            r_q    <= SW'(i_query_sum);
            r_q_ok <= (SW'(i_query_sum) < MAX_S);
        end
        r_p_first <= first;
        r_p_drop  <= drop;
        r_p_addr  <= r_j[AW-1:0];
        if (i_cmd.add_start) begin
            r_r    <= '0;
            r_j    <= '0;
            r_tail <= '0;
            r_k    <= '0;
        end else if (i_cmd.walk) begin
            if (class_end) begin
                r_r    <= n_r_step;
                r_j    <= n_r_step;
                r_tail <= n_r_step;
                r_k    <= '0;
            end else begin
                r_j <= n_j_step;
                r_k <= r_k + SW'(1);
                if (drop) begin
                    r_tail <= r_tail + w_ext;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_j < MAX_S))
        else $error("walk head past bitmap");

    a_tail_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && drop) |-> (r_tail < r_j))
        else $error("window tail not behind head");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_wr && r_p_valid))
        else $error("clear and walk write collide");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_p_valid) |-> (r_count <= CW'(r_c) + CW'(1)))
        else $error("window count exceeds window length");
`endif

endmodule

`default_nettype wire

### design/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl: controller
// Sequences clear sweeps, add walks and queries; owns both handshakes
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire bsr_pkg::t_action              i_action,
    input  wire logic [bsr_pkg::FIELD_W-1:0]   i_weight,
    input  wire logic [bsr_pkg::FIELD_W-1:0]   i_mult,
    output bsr_pkg::t_dp_cmd                   o_cmd,
    input  wire bsr_pkg::t_dp_sts              i_sts,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic                               o_reachable
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_FLUSH,
        S_QRD,
        S_QOUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_out_data;
    logic   accept, out_load;

    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_reachable = r_out_data;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        out_load = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        bsr_pkg::ACT_ADD: begin
                            if (i_weight != '0 && i_mult != '0) begin
                                o_cmd.add_start = 1'b1;
                                n_state         = S_ADD;
                            end
                        end
                        bsr_pkg::ACT_QUERY: begin
                            n_state = S_QRD;
                        end
                        bsr_pkg::ACT_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state         = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;   // unused code: dropped
                        end
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flip = 1'b1;   // last shadow write lands at this edge
                n_state    = S_IDLE;
            end
            S_QRD: begin
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (out_load) begin
            r_out_data <= i_sts.q_bit;
        end
    end

endmodule

`default_nettype wire

### design/bounded_subset_sum_reach.sv
// ----------------------------------------------------------------------------
// bounded_subset_sum_reach: bounded subset-sum reachability bitmap
// Keeps one bit per sum below MAX_SUM; add folds in a weight group of
// bounded multiplicity, query reads one bit, clear restores {0}.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake               payload
//  -------  ---  ----------------------  -----------------------------------
//  s        in   i_s_tvalid/o_s_tready   tuser: action; tdata: weight,
//                                        multiplicity, query_sum
//  m        out  o_m_tvalid/i_m_tready   tdata: reachable (query only)
//
//  add    : the walk visits each bitmap position once,
//           one position per cycle through the dual-read bank.
//  query  : read in S_QRD, loaded in S_QOUT; clear: sweeps every entry.
//  reset  : i_rst_n synchronous; a clearing pass over the whole bitmap
//           follows, o_s_tready stays low until it is done.
//  stalls : o_s_tready is high only when idle; a waiting result does not
//           block add or clear items, a second query waits for the slot.
//
// Add walk: each residue class r mod w is walked in order. A window count
// holds the number of set bits among the previous multiplicity positions of
// the class; a position becomes reachable when the count is nonzero. Old
// bits come from the live bank, new bits go to the shadow bank, and the
// banks swap at the end of the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_subset_sum_reach #(
    parameter int MAX_SUM = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // weight[11:0], multiplicity[23:12],
                                          // query_sum[35:24], zero pad[39:36]
    input  wire logic [1:0]  i_s_tuser,   // action[1:0]
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata    // reachable[0], zero pad[7:1]
);

    bsr_pkg::t_dp_cmd cmd;
    bsr_pkg::t_dp_sts sts;
    bsr_pkg::t_action action;
    logic             reachable;

    assign action    = bsr_pkg::t_action'(i_s_tuser);
    assign o_m_tdata = {7'd0, reachable};

    bsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_action    (action),
        .i_weight    (i_s_tdata[11:0]),
        .i_mult      (i_s_tdata[23:12]),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_reachable (reachable)
    );

    bsr_dp #(.MAX_SUM(MAX_SUM)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_weight    (i_s_tdata[11:0]),
        .i_mult      (i_s_tdata[23:12]),
        .i_query_sum (i_s_tdata[35:24]),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

### tb/bounded_subset_sum_reach_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_subset_sum_reach_tb: self-checking bench for the subset-sum bitmap
// Walks a directed table (reset state, extremes, zero weight/count, unused
// action, clear), then random add/query/clear runs with bursty input and a
// stalling output; every query result is checked against the bitmap predictor or a typed-in answer.
// ----------------------------------------------------------------------------

module bounded_subset_sum_reach_tb;

    localparam int          MAP_SIZE    = 4096;
    localparam int          RAND_ITEMS  = 114;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;   // spare action code, ignored
    localparam int          NO_KNOWN    = -1;     // row result comes from predictor

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // weight[11:0], multiplicity[23:12],
                                    // query_sum[35:24], zero pad[39:36]
    logic [1:0]  i_s_tuser  = '0;   // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // reachable[0], zero pad[7:1]

    bounded_subset_sum_reach #(
        .MAX_SUM (MAP_SIZE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: one bit per sum, plus the queue of pending query
    // answers in the order the items were accepted.
    // ------------------------------------------------------------------------
    logic [MAP_SIZE-1:0] reach_map;
    bit                  reach_answers_q[$];
    int                  fail_count  = 0;
    int                  burst_left  = 0;
    bit                  hold_request = 1'b0;

    function automatic void reset_reach_map();
        reach_map    = '0;
        reach_map[0] = 1'b1;
    endfunction

    // Append one expected answer at the tail of the pending queue.
    function automatic void queue_answer(input bit answer);
        reach_answers_q = {reach_answers_q, answer};
    endfunction

    // Fold in c copies of weight w. Per residue class the window counts the
    // set bits among the previous c positions of the old map; a position
    // becomes reachable whenever that count is nonzero. Sums past the map
    // simply fall off the end of each class walk.
    function automatic void fold_weight_group(input int unsigned w, input int unsigned c);
        logic [MAP_SIZE-1:0] prior;
        int unsigned         cnt;
        int unsigned         len;
        int unsigned         r;
        int unsigned         j;
        if (w == 0 || c == 0)
            return;
        prior = reach_map;
        for (r = 0; r < w && r < MAP_SIZE; r++) begin
            cnt = 0;
            len = 0;
            for (j = r; j < MAP_SIZE; j += w) begin
                if (len > c) begin
                    cnt -= 32'(prior[j - w * len]);
                    len--;
                end
                if (cnt != 0)
                    reach_map[j] = 1'b1;
                cnt += 32'(prior[j]);
                len++;
            end
        end
    endfunction

    // Update the predictor for one accepted item. A query queues its answer,
    // either the typed-in value or the bitmap bit.
    function automatic void predict_item(input logic [1:0] act, input logic [11:0] w,
                                         input logic [11:0] c, input logic [11:0] q,
                                         input int known);
        case (act)
            bsr_pkg::ACT_ADD: begin
                fold_weight_group(32'(w), 32'(c));
            end
            bsr_pkg::ACT_QUERY: begin
                if (known != NO_KNOWN)
                    queue_answer(known[0]);
                else
                    queue_answer(reach_map[q]);
            end
            bsr_pkg::ACT_CLEAR: begin
                reset_reach_map();
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length; between bursts valid
    // drops for a random gap (sometimes none). Valid is never lowered and
    // raised in the same step.
    // ------------------------------------------------------------------------
    task automatic offer(input logic [1:0] act, input logic [11:0] w, input logic [11:0] c,
                         input logic [11:0] q, input int known);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, q, c, w};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        predict_item(act, w, c, q, known);
    endtask

    // Drop valid and hold until every pending answer has come back.
    task automatic drain_answers();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (reach_answers_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Ready follows a random mode that is chosen anew when its run
    // ends; on request it holds ready low until hold_left runs out, so the
    // result slot stays full and the next query backs up the input.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int mode      = 0;
    int mode_left = 0;
    int rx_phase  = 0;

    always @(posedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        rx_phase++;
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= 1'($urandom_range(0, 1));
                2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= rx_phase[2];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each accepted result against the oldest pending answer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reach_answers_q.size() == 0) begin
                $error("unexpected result item, reachable %0d", o_m_tdata[0]);
                fail_count++;
            end else begin
                if (o_m_tdata[0] !== reach_answers_q[0]) begin
                    $error("reachable: expected %0d, got %0d", reach_answers_q[0],
                           o_m_tdata[0]);
                    fail_count++;
                end
                if (o_m_tdata[7:1] !== 7'd0) begin
                    $error("pad: expected 0, got %0h", o_m_tdata[7:1]);
                    fail_count++;
                end
                void'(reach_answers_q.pop_front());
            end
        end
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table: reset state, zero weight/count, extreme weight and
    // count, sums past the map, unused action, clear.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [1:0]  act;
        logic [11:0] w;
        logic [11:0] c;
        logic [11:0] q;
        int          known;
    } t_row;

    localparam int N_ROWS = 26;

    t_row directed_rows [0:N_ROWS-1] = '{
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd0,    1},        // only sum 0 after reset
        '{bsr_pkg::ACT_QUERY, 12'hfff,  12'hfff,  12'd4095, 0},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd1,    0},
        '{bsr_pkg::ACT_ADD,   12'd0,    12'd5,    12'hfff,  NO_KNOWN}, // zero weight: no change
        '{bsr_pkg::ACT_ADD,   12'd3,    12'd0,    12'hfff,  NO_KNOWN}, // zero count: no change
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd3,    0},
        '{bsr_pkg::ACT_ADD,   12'd4095, 12'd4095, 12'h000,  NO_KNOWN}, // max weight and count
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'hfff,  12'd4095, 1},
        '{bsr_pkg::ACT_QUERY, 12'hfff,  12'h000,  12'd4094, 0},
        '{bsr_pkg::ACT_CLEAR, 12'hfff,  12'hfff,  12'hfff,  NO_KNOWN},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd4095, 0},
        '{bsr_pkg::ACT_ADD,   12'd1,    12'd4095, 12'h000,  NO_KNOWN}, // fills the whole map
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd4095, 1},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd2048, NO_KNOWN},
        '{bsr_pkg::ACT_CLEAR, 12'h000,  12'h000,  12'h000,  NO_KNOWN},
        '{bsr_pkg::ACT_ADD,   12'd5,    12'd3,    12'h000,  NO_KNOWN},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd15,   NO_KNOWN},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd20,   NO_KNOWN},
        '{bsr_pkg::ACT_ADD,   12'd7,    12'd2,    12'h000,  NO_KNOWN},
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd29,   NO_KNOWN},
        '{ACT_UNUSED,         12'hfff,  12'hfff,  12'hfff,  NO_KNOWN}, // spare code: ignored
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd22,   NO_KNOWN},
        '{bsr_pkg::ACT_ADD,   12'd2048, 12'd4095, 12'h000,  NO_KNOWN}, // most sums fall off
        '{bsr_pkg::ACT_QUERY, 12'h000,  12'h000,  12'd4095, NO_KNOWN},
        '{bsr_pkg::ACT_CLEAR, 12'h000,  12'h000,  12'h000,  NO_KNOWN},
        '{bsr_pkg::ACT_QUERY, 12'hfff,  12'hfff,  12'd0,    1}
    };

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          row;
        int          items_done;
        int          n_adds;
        int          n_queries;
        int          k;
        bit          pressure_done;
        logic [1:0]  act;
        logic [11:0] w;
        logic [11:0] c;
        logic [11:0] q;

        reset_reach_map();
        items_done    = 0;
        pressure_done = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++)
            offer(directed_rows[row].act, directed_rows[row].w, directed_rows[row].c,
                  directed_rows[row].q, directed_rows[row].known);
        drain_answers();

        while (items_done < RAND_ITEMS) begin
            if (items_done >= RAND_ITEMS / 2 && !pressure_done) begin
                // sender waits for the pipeline to empty, then floods queries
                // while the receiver is held off
                drain_answers();
                offer(bsr_pkg::ACT_QUERY, 12'($urandom), 12'($urandom),
                      12'($urandom_range(0, 127)), NO_KNOWN);
                hold_request = 1'b1;
                for (k = 0; k < 6; k++)
                    offer(bsr_pkg::ACT_QUERY, 12'($urandom), 12'($urandom),
                          12'($urandom_range(0, 127)), NO_KNOWN);
                items_done += 7;
                pressure_done = 1'b1;
            end else if ($urandom_range(0, 99) < 80) begin
                // well-formed run: optional clear, a few adds, then queries
                if ($urandom_range(0, 3) == 0) begin
                    offer(bsr_pkg::ACT_CLEAR, 12'($urandom), 12'($urandom),
                          12'($urandom), NO_KNOWN);
                    items_done++;
                end
                n_adds = $urandom_range(1, 3);
                for (k = 0; k < n_adds; k++) begin
                    case ($urandom_range(0, 9))
                        0:       w = 12'd0;
                        1, 2:    w = 12'($urandom_range(1, 4095));
                        default: w = 12'($urandom_range(1, 40));
                    endcase
                    case ($urandom_range(0, 9))
                        0:          c = 12'd0;
                        1, 2, 3, 4: c = 12'($urandom_range(0, 4095));
                        default:    c = 12'($urandom_range(1, 6));
                    endcase
                    offer(bsr_pkg::ACT_ADD, w, c, 12'($urandom), NO_KNOWN);
                    items_done++;
                end
                n_queries = $urandom_range(2, 6);
                for (k = 0; k < n_queries; k++) begin
                    q = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 127))
                                                    : 12'($urandom_range(0, 4095));
                    offer(bsr_pkg::ACT_QUERY, 12'($urandom), 12'($urandom), q, NO_KNOWN);
                    items_done++;
                end
            end else begin
                // noise: any action code, any field values
                act = 2'($urandom_range(0, 3));
                w   = 12'($urandom);
                c   = 12'($urandom);
                q   = 12'($urandom);
                offer(act, w, c, q, NO_KNOWN);
                items_done++;
            end
        end

        i_s_tvalid <= 1'b0;
        while (reach_answers_q.size() != 0)
            @(posedge i_clk);
        // an add or clear may still be walking the map
        repeat (MAP_SIZE + 16) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/bsr_pkg.sv
design/bsr_ram.sv
design/bsr_dp.sv
design/bsr_ctrl.sv
design/bounded_subset_sum_reach.sv
tb/bounded_subset_sum_reach_tb.sv
